### hdl/tmvg_pkg.sv
// ----------------------------------------------------------------------------
// tmvg_pkg
// Types and fixed constants shared by the text-mode video generator modules.
// ----------------------------------------------------------------------------
package tmvg_pkg;

   localparam int MEM_ADDR_BITS = 16;
   localparam int MEM_DEPTH     = 2 ** MEM_ADDR_BITS;
   localparam int COLOR_W       = 12;
   localparam int CSR_INDEX_W   = 3;

   // Screen geometry: a 320 x 200 text area inside a 16 pixel border.
   localparam logic [8:0] SCREEN_W_LAST = 9'd351;
   localparam logic [7:0] SCREEN_H      = 8'd232;
   localparam logic [7:0] LAST_DRAWN    = 8'd231;
   localparam logic [8:0] EDGE_X        = 9'd16;
   localparam logic [7:0] EDGE_Y        = 8'd16;
   localparam logic [8:0] TEXT_X_END    = 9'd336;
   localparam logic [7:0] TEXT_Y_END    = 8'd216;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_BORDER     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BACKGROUND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FOREGROUND = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_PAGE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CHARMAP    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RASTER     = 3'd5;

   localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 12'h0EEE;
   localparam logic [7:0]         FRAME_PAGE_RESET = 8'hF0;
   localparam logic [7:0]         CHARMAP_RESET    = 8'hF4;
   localparam logic [7:0]         RASTER_RESET     = 8'hFF;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_BLANK,
      KIND_BORDER,
      KIND_TEXT
   } work_kind_type;

   typedef struct packed {
      work_kind_type            kind;
      logic [MEM_ADDR_BITS-1:0] addr;
      logic [7:0]               data;
      logic [2:0]               row;
      logic [2:0]               bit_sel;
      logic                     line_end;
      logic                     frame_done;
      logic                     raster_irq;
      logic [7:0]               current_line;
   } work_item_type;

   typedef struct packed {
      logic [COLOR_W-1:0] border_color;
      logic [COLOR_W-1:0] background_color;
      logic [COLOR_W-1:0] foreground_color;
      logic [7:0]         charmap_page;
   } cfg_type;

   typedef struct packed {
      logic               pixel_valid;
      logic [COLOR_W-1:0] pixel_color;
      logic               line_end;
      logic               frame_done;
      logic               raster_irq;
      logic [7:0]         current_line;
   } rsp_item_type;

endpackage

### hdl/tmvg_if.sv
// ----------------------------------------------------------------------------
// tmvg channel interfaces
// Valid/ready channels for request words, result words and register writes.
// ----------------------------------------------------------------------------
interface tmvg_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] mem_addr;
   logic [7:0]  mem_data;

   modport source (output valid, output cmd, output mem_addr, output mem_data,
                   input ready);
   modport sink   (input valid, input cmd, input mem_addr, input mem_data,
                   output ready);
endinterface

interface tmvg_rsp_if;
   logic        valid;
   logic        ready;
   logic        pixel_valid;
   logic [11:0] pixel_color;
   logic        line_end;
   logic        frame_done;
   logic        raster_irq;
   logic [7:0]  current_line;

   modport source (output valid, output pixel_valid, output pixel_color,
                   output line_end, output frame_done, output raster_irq,
                   output current_line, input ready);
   modport sink   (input valid, input pixel_valid, input pixel_color,
                   input line_end, input frame_done, input raster_irq,
                   input current_line, output ready);
endinterface

interface tmvg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/tmvg_queue.sv
// ----------------------------------------------------------------------------
// tmvg_queue
// Small first-in first-out buffer of words with an occupancy count.
// ----------------------------------------------------------------------------
module tmvg_queue #(
   parameter type ITEM_TYPE  = logic,
   parameter int  DEPTH_LOG2 = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ITEM_TYPE            push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ITEM_TYPE            pop_item,
   output logic [DEPTH_LOG2:0] count
);
   localparam int DEPTH = 2 ** DEPTH_LOG2;

   ITEM_TYPE              slot_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ff, wr_in;
   logic [DEPTH_LOG2-1:0] rd_ff, rd_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != (DEPTH_LOG2 + 1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ff];
   assign count      = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

### hdl/tmvg_front.sv
// ----------------------------------------------------------------------------
// tmvg_front
// Accepts request words, keeps the beam counters and the control registers,
// and classifies each pixel tick into blank, border or text with its address.
// ----------------------------------------------------------------------------
module tmvg_front #(
   parameter int LINES_PER_FRAME = 256,
   parameter int TEXT_COLUMNS    = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   tmvg_req_if.sink               req_bus,
   tmvg_csr_if.sink               csr_bus,
   input  logic                   hold,
   output tmvg_pkg::cfg_type       cfg,
   output logic                   push_valid,
   input  logic                   push_ready,
   output tmvg_pkg::work_item_type push_item
);
   import tmvg_pkg::*;

   logic [8:0]         pixel_ff, pixel_in;
   logic [7:0]         line_ff, line_in;
   logic [COLOR_W-1:0] border_ff, background_ff, foreground_ff;
   logic [7:0]         frame_page_ff, charmap_ff, raster_ff;

   logic                     accept, last, drawn, in_text;
   logic [8:0]               fx, line_inc;
   logic [7:0]               fy;
   logic [MEM_ADDR_BITS-1:0] char_addr;

   assign req_bus.ready = push_ready && !hold;
   assign push_valid    = req_bus.valid && !hold;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign cfg.border_color     = border_ff;
   assign cfg.background_color = background_ff;
   assign cfg.foreground_color = foreground_ff;
   assign cfg.charmap_page     = charmap_ff;

   always_comb begin
      last     = (pixel_ff >= SCREEN_W_LAST);
      drawn    = (line_ff < SCREEN_H);
      in_text  = (line_ff >= EDGE_Y) && (line_ff < TEXT_Y_END) &&
                 (pixel_ff >= EDGE_X) && (pixel_ff < TEXT_X_END);
      fx       = pixel_ff - EDGE_X;
      fy       = line_ff - EDGE_Y;
      line_inc = {1'b0, line_ff} + 9'd1;
      // Character cell address: page base plus row times stride plus column.
      char_addr = {frame_page_ff, 8'h00}
                + MEM_ADDR_BITS'(16'(fy[7:3]) * 16'(TEXT_COLUMNS))
                + MEM_ADDR_BITS'(fx[8:3]);

      push_item              = '0;
      push_item.current_line = line_ff;
      if (req_bus.cmd == CMD_WRITE) begin
         push_item.kind = KIND_WRITE;
         push_item.addr = req_bus.mem_addr;
         push_item.data = req_bus.mem_data;
      end else begin
         if (!drawn) begin
            push_item.kind = KIND_BLANK;
         end else if (in_text) begin
            push_item.kind = KIND_TEXT;
         end else begin
            push_item.kind = KIND_BORDER;
         end
         push_item.addr       = char_addr;
         push_item.row        = fy[2:0];
         push_item.bit_sel    = fx[2:0];
         push_item.line_end   = last;
         push_item.frame_done = last && (line_ff == LAST_DRAWN);
         push_item.raster_irq = last && drawn && (line_inc == {1'b0, raster_ff});
      end

      pixel_in = pixel_ff;
      line_in  = line_ff;
      if (accept && req_bus.cmd == CMD_TICK) begin
         if (last) begin
            pixel_in = '0;
            line_in  = (line_inc >= 9'(LINES_PER_FRAME)) ? 8'd0 : line_inc[7:0];
         end else begin
            pixel_in = pixel_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff      <= '0;
         line_ff       <= '0;
         border_ff     <= '0;
         background_ff <= '0;
         foreground_ff <= FOREGROUND_RESET;
         frame_page_ff <= FRAME_PAGE_RESET;
         charmap_ff    <= CHARMAP_RESET;
         raster_ff     <= RASTER_RESET;
      end else begin
         pixel_ff <= pixel_in;
         line_ff  <= line_in;
         if (csr_bus.valid) begin
            case (csr_bus.index)
               REG_BORDER:     border_ff     <= csr_bus.data;
               REG_BACKGROUND: background_ff <= csr_bus.data;
               REG_FOREGROUND: foreground_ff <= csr_bus.data;
               REG_FRAME_PAGE: frame_page_ff <= csr_bus.data[7:0];
               REG_CHARMAP:    charmap_ff    <= csr_bus.data[7:0];
               REG_RASTER:     raster_ff     <= csr_bus.data[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule

### hdl/tmvg_back.sv
// ----------------------------------------------------------------------------
// tmvg_back
// Owns the video memory. Applies byte writes, fetches character code and glyph
// row in two pipelined reads, picks the colour and queues the result words.
// ----------------------------------------------------------------------------
module tmvg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tmvg_pkg::cfg_type       cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  tmvg_pkg::work_item_type pop_item,
   output logic                   clearing,
   tmvg_rsp_if.source             rsp_bus
);
   import tmvg_pkg::*;

   localparam int OUTQ_LOG2 = 2;
   localparam int OUTQ_SUM_W = OUTQ_LOG2 + 2;

   logic [7:0]               mem_ff [MEM_DEPTH];
   logic [MEM_ADDR_BITS:0]   clr_ff;
   logic [7:0]               code_ff, glyph_ff;
   logic                     s1_valid_ff, s2_valid_ff;
   work_item_type            s1_item_ff, s2_item_ff;

   logic                     take, mem_we;
   logic [MEM_ADDR_BITS-1:0] mem_wa, glyph_addr;
   logic [7:0]               mem_wd, glyph_shifted;
   logic [OUTQ_LOG2:0]       outq_count;
   logic [OUTQ_SUM_W-1:0]    committed;
   rsp_item_type             rsp_item, outq_head;
   logic                     outq_valid;

   assign clearing = !clr_ff[MEM_ADDR_BITS];

   // A word enters the pipeline only if the result queue will have room for it
   // together with every word already in flight.
   assign committed = OUTQ_SUM_W'(outq_count) + OUTQ_SUM_W'(s1_valid_ff)
                    + OUTQ_SUM_W'(s2_valid_ff);
   assign pop_ready = !clearing && (committed < OUTQ_SUM_W'(2 ** OUTQ_LOG2));
   assign take      = pop_valid && pop_ready;

   always_comb begin
      mem_we = clearing || (take && pop_item.kind == KIND_WRITE);
      mem_wa = clearing ? clr_ff[MEM_ADDR_BITS-1:0] : pop_item.addr;
      mem_wd = clearing ? 8'h00 : pop_item.data;
      glyph_addr = {cfg.charmap_page, 8'h00}
                 + MEM_ADDR_BITS'({code_ff, 3'b000})
                 + MEM_ADDR_BITS'(s1_item_ff.row);
   end

   // Reads return the old byte when the same address is written in that cycle,
   // which keeps a later write from reaching an earlier pixel's glyph fetch.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      code_ff  <= mem_ff[pop_item.addr];
      glyph_ff <= mem_ff[glyph_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (clearing) begin
            clr_ff <= clr_ff + 1'b1;
         end
         s1_valid_ff <= take;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= pop_item;
      s2_item_ff <= s1_item_ff;
   end

   always_comb begin
      glyph_shifted         = glyph_ff << s2_item_ff.bit_sel;
      rsp_item.pixel_valid  = 1'b0;
      rsp_item.pixel_color  = '0;
      rsp_item.line_end     = s2_item_ff.line_end;
      rsp_item.frame_done   = s2_item_ff.frame_done;
      rsp_item.raster_irq   = s2_item_ff.raster_irq;
      rsp_item.current_line = s2_item_ff.current_line;
      case (s2_item_ff.kind)
         KIND_WRITE: ;
         KIND_BLANK: ;
         KIND_BORDER: begin
            rsp_item.pixel_valid = 1'b1;
            rsp_item.pixel_color = cfg.border_color;
         end
         KIND_TEXT: begin
            rsp_item.pixel_valid = 1'b1;
            rsp_item.pixel_color = glyph_shifted[7] ? cfg.foreground_color
                                                    : cfg.background_color;
         end
         default: ;
      endcase
   end

   tmvg_queue #(
      .ITEM_TYPE  (rsp_item_type),
      .DEPTH_LOG2 (OUTQ_LOG2)
   ) u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s2_valid_ff),
      .push_ready (),
      .push_item  (rsp_item),
      .pop_valid  (outq_valid),
      .pop_ready  (rsp_bus.ready),
      .pop_item   (outq_head),
      .count      (outq_count)
   );

   assign rsp_bus.valid        = outq_valid;
   assign rsp_bus.pixel_valid  = outq_head.pixel_valid;
   assign rsp_bus.pixel_color  = outq_head.pixel_color;
   assign rsp_bus.line_end     = outq_head.line_end;
   assign rsp_bus.frame_done   = outq_head.frame_done;
   assign rsp_bus.raster_irq   = outq_head.raster_irq;
   assign rsp_bus.current_line = outq_head.current_line;

endmodule

### hdl/text_mode_video_generator_top.sv
// ----------------------------------------------------------------------------
// text_mode_video_generator_top
// Text-mode video generator: 40 x 25 character cells inside a border.
// ----------------------------------------------------------------------------
// Throughput: one word per clock, writes and pixel ticks alike, while the result
// side takes words and the video memory is not being cleared. A request passes
// through the word queue, the two dependent video memory reads and the result
// queue before its result word is offered. Reset is synchronous; afterwards the
// 65536 byte video memory is cleared one byte a cycle, and requests are refused
// until it is done (register writes are taken throughout).
module text_mode_video_generator_top #(
   parameter int LINES_PER_FRAME = 256,
   parameter int TEXT_COLUMNS    = 40
) (
   input  logic        clock,
   input  logic        reset,
   tmvg_req_if.sink    req_bus,
   tmvg_csr_if.sink    csr_bus,
   tmvg_rsp_if.source  rsp_bus
);
   import tmvg_pkg::*;

   cfg_type       cfg;
   logic          clearing;
   logic          fq_push_valid, fq_push_ready;
   work_item_type fq_push_item;
   logic          fq_pop_valid, fq_pop_ready;
   work_item_type fq_pop_item;

   tmvg_front #(
      .LINES_PER_FRAME (LINES_PER_FRAME),
      .TEXT_COLUMNS    (TEXT_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .hold       (clearing),
      .cfg        (cfg),
      .push_valid (fq_push_valid),
      .push_ready (fq_push_ready),
      .push_item  (fq_push_item)
   );

   tmvg_queue #(
      .ITEM_TYPE  (work_item_type),
      .DEPTH_LOG2 (2)
   ) u_workq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_push_valid),
      .push_ready (fq_push_ready),
      .push_item  (fq_push_item),
      .pop_valid  (fq_pop_valid),
      .pop_ready  (fq_pop_ready),
      .pop_item   (fq_pop_item),
      .count      ()
   );

   tmvg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (fq_pop_valid),
      .pop_ready (fq_pop_ready),
      .pop_item  (fq_pop_item),
      .clearing  (clearing),
      .rsp_bus   (rsp_bus)
   );

endmodule

### tb/text_mode_video_generator_top_tb.sv
// ----------------------------------------------------------------------------
// text_mode_video_generator_top_tb
// Drives pixel ticks and video memory writes into the text-mode generator and
// checks every result word against an in-bench model of the screen raster,
// the character and glyph look-ups and the raster interrupt. The run covers
// the first lines of a frame, their line ends and raster interrupts under
// several register settings and under three patterns of flow control.
// ----------------------------------------------------------------------------
module text_mode_video_generator_top_tb;
   import tmvg_pkg::*;

   localparam int LINES_PER_FRAME = 256;
   localparam int TEXT_COLUMNS    = 40;
   localparam int CLOCK_PERIOD    = 10;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PHASE_WORDS     = 204;

   class video_scoreboard;
      bit [7:0]           vram [MEM_DEPTH];
      int                 line_no;
      int                 pixel_no;
      logic [COLOR_W-1:0] border_color;
      logic [COLOR_W-1:0] background_color;
      logic [COLOR_W-1:0] foreground_color;
      logic [7:0]         frame_page;
      logic [7:0]         charmap_page;
      logic [7:0]         raster_line;
      rsp_item_type       pending_pixels [$];
      int                 errors;
      int                 ticks;
      int                 writes;
      int                 irqs;
      int                 frames;
      int                 lines_swept;

      function new();
         foreach (vram[i]) vram[i] = 8'h00;
         line_no          = 0;
         pixel_no         = 0;
         border_color     = '0;
         background_color = '0;
         foreground_color = FOREGROUND_RESET;
         frame_page       = FRAME_PAGE_RESET;
         charmap_page     = CHARMAP_RESET;
         raster_line      = RASTER_RESET;
         errors           = 0;
         ticks            = 0;
         writes           = 0;
         irqs             = 0;
         frames           = 0;
         lines_swept      = 0;
      endfunction

      function void flag_failure(string what);
         errors++;
         $error("%s", what);
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [11:0] value);
         case (index)
            REG_BORDER:     border_color     = value;
            REG_BACKGROUND: background_color = value;
            REG_FOREGROUND: foreground_color = value;
            REG_FRAME_PAGE: frame_page       = value[7:0];
            REG_CHARMAP:    charmap_page     = value[7:0];
            REG_RASTER:     raster_line      = value[7:0];
            default: ;
         endcase
      endfunction

      // Works out the result word for one accepted request and queues it.
      function void note_request(logic cmd, logic [15:0] addr, logic [7:0] data);
         rsp_item_type pix;
         logic [8:0]   fx;
         logic [7:0]   fy;
         logic [15:0]  cell_addr;
         logic [15:0]  glyph_addr;
         logic [7:0]   code;
         logic         drawn;
         logic         last;
         pix = '0;
         pix.current_line = line_no[7:0];
         if (cmd == CMD_WRITE) begin
            vram[addr] = data;
            writes++;
         end else begin
            drawn = line_no < SCREEN_H;
            last  = pixel_no == SCREEN_W_LAST;
            if (drawn) begin
               if (line_no >= EDGE_Y && line_no < TEXT_Y_END &&
                   pixel_no >= EDGE_X && pixel_no < TEXT_X_END) begin
                  fx = 9'(pixel_no) - EDGE_X;
                  fy = 8'(line_no) - EDGE_Y;
                  // Both look-ups wrap round the top of the 64 KiB video memory.
                  cell_addr  = 16'({frame_page, 8'h00} + (fy >> 3) * TEXT_COLUMNS
                                   + (fx >> 3));
                  code       = vram[cell_addr];
                  glyph_addr = 16'({charmap_page, 8'h00} + code * 8 + fy[2:0]);
                  pix.pixel_color = vram[glyph_addr][3'd7 - fx[2:0]] ?
                                    foreground_color : background_color;
               end else begin
                  pix.pixel_color = border_color;
               end
            end
            pix.pixel_valid = drawn;
            pix.line_end    = last;
            pix.frame_done  = last && line_no == LAST_DRAWN;
            pix.raster_irq  = last && drawn && (line_no + 1 == raster_line);
            ticks++;
            irqs   += pix.raster_irq;
            frames += pix.frame_done;
            if (last) begin
               pixel_no = 0;
               lines_swept++;
               line_no = (line_no + 1 >= LINES_PER_FRAME) ? 0 : line_no + 1;
            end else begin
               pixel_no++;
            end
         end
         pending_pixels.push_back(pix);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got)
            flag_failure($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
      endfunction

      function void check_pixel(rsp_item_type got);
         rsp_item_type want;
         if (pending_pixels.size() == 0) begin
            flag_failure($sformatf("result word %p arrived with nothing expected", got));
         end else begin
            want = pending_pixels.pop_front();
            compare_field("pixel_valid",  want.pixel_valid,  got.pixel_valid);
            compare_field("pixel_color",  want.pixel_color,  got.pixel_color);
            compare_field("line_end",     want.line_end,     got.line_end);
            compare_field("frame_done",   want.frame_done,   got.frame_done);
            compare_field("raster_irq",   want.raster_irq,   got.raster_irq);
            compare_field("current_line", want.current_line, got.current_line);
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   int              req_gap_pct;
   int              rsp_stall_pct;
   int              settings_applied;
   video_scoreboard board;

   tmvg_req_if req_bus ();
   tmvg_csr_if csr_bus ();
   tmvg_rsp_if rsp_bus ();

   text_mode_video_generator_top #(
      .LINES_PER_FRAME(LINES_PER_FRAME),
      .TEXT_COLUMNS   (TEXT_COLUMNS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .csr_bus(csr_bus),
      .rsp_bus(rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Allows for the memory clearing pass and the slowest flow-control phases
   // many times over.
   initial begin
      #(CLOCK_PERIOD * 2_000_000);
      $display("TEST FAILED");
      $finish;
   end

   // Result side: checks each word taken and stalls at random.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            board.check_pixel({rsp_bus.pixel_valid, rsp_bus.pixel_color, rsp_bus.line_end,
                               rsp_bus.frame_done, rsp_bus.raster_irq, rsp_bus.current_line});
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_word(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
      while ($urandom_range(99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= cmd;
      req_bus.mem_addr <= addr;
      req_bus.mem_data <= data;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(cmd, addr, data);
   endtask

   task automatic send_random_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 88)
         send_word(CMD_TICK, 16'($urandom), 8'($urandom));
      else if (pick < 93)
         // Character codes somewhere in the visible part of the frame page.
         send_word(CMD_WRITE, {board.frame_page, 8'h00} + 16'($urandom_range(999)),
                   8'($urandom));
      else if (pick < 98)
         send_word(CMD_WRITE, {board.charmap_page, 8'h00} + 16'($urandom_range(2047)),
                   8'($urandom));
      else
         send_word(CMD_WRITE, 16'($urandom), 8'($urandom));
   endtask

   task automatic run_words(input int count);
      repeat (count) send_random_word();
   endtask

   task automatic wait_until_idle();
      int waited;
      req_bus.valid <= 1'b0;
      waited = 0;
      while (board.pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [11:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_reg(index, value);
   endtask

   task automatic apply_settings(input logic [11:0] border, background, foreground,
                                 frame, charmap, raster);
      write_csr(REG_BORDER, border);
      write_csr(REG_BACKGROUND, background);
      write_csr(REG_FOREGROUND, foreground);
      write_csr(REG_FRAME_PAGE, frame);
      write_csr(REG_CHARMAP, charmap);
      write_csr(REG_RASTER, raster);
      csr_bus.valid <= 1'b0;
      settings_applied++;
   endtask

   initial begin
      board            = new();
      settings_applied = 0;
      req_gap_pct      = 21;
      rsp_stall_pct    = 78;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= CMD_TICK;
      req_bus.mem_addr <= '0;
      req_bus.mem_data <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= REG_BORDER;
      csr_bus.data     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A raster register of zero can never match a drawn line.
      apply_settings(12'hFFF, 12'h000, FOREGROUND_RESET, 12'h0F0, 12'h0F4, 12'h000);
      send_word(CMD_WRITE, 16'h0000, 8'hFF);
      send_word(CMD_WRITE, 16'hFFFF, 8'h00);
      send_word(CMD_TICK,  16'hFFFF, 8'hFF);
      send_word(CMD_WRITE, 16'hFFFF, 8'hFF);
      send_word(CMD_WRITE, 16'h0000, 8'h00);
      send_word(CMD_TICK,  16'h0000, 8'h00);
      send_word(CMD_WRITE, 16'hA55A, 8'hA5);
      send_word(CMD_WRITE, 16'h5AA5, 8'h5A);
      // Character codes and a glyph in the default pages, written back to back.
      send_word(CMD_WRITE, 16'hF000, 8'h01);
      send_word(CMD_WRITE, 16'hF027, 8'h01);
      send_word(CMD_WRITE, 16'hF028, 8'h01);
      send_word(CMD_WRITE, 16'hF408, 8'h81);
      send_word(CMD_WRITE, 16'hF409, 8'hFF);
      send_word(CMD_WRITE, 16'hF40A, 8'h00);
      send_word(CMD_WRITE, 16'hF40B, 8'hAA);
      send_word(CMD_WRITE, 16'hF40C, 8'h55);
      send_word(CMD_WRITE, 16'hF40D, 8'h18);
      send_word(CMD_WRITE, 16'hF40E, 8'h3C);
      send_word(CMD_WRITE, 16'hF40F, 8'h7E);
      send_word(CMD_TICK,  16'h1234, 8'h56);
      run_words(PHASE_WORDS);

      // The interrupt is aimed at the end of the line the beam is on.
      wait_until_idle();
      apply_settings(12'h000, 12'($urandom), 12'($urandom), 12'h0F0, 12'h0F4,
                     12'(board.line_no + 1));
      run_words(PHASE_WORDS);

      wait_until_idle();
      req_gap_pct   = 78;
      rsp_stall_pct = 21;
      // Top pages make both the character and the glyph addresses wrap.
      apply_settings(12'($urandom), 12'hFFF, 12'h000, 12'h0FF, 12'h0FF, 12'd232);
      run_words(PHASE_WORDS);

      wait_until_idle();
      apply_settings(12'($urandom), 12'($urandom), 12'($urandom), 12'h000, 12'($urandom),
                     12'(board.line_no + 1));
      run_words(PHASE_WORDS);

      wait_until_idle();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      apply_settings(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), 12'h000,
                     12'(board.line_no + 2));
      run_words(PHASE_WORDS);

      wait_until_idle();
      apply_settings(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 12'hFFF);
      run_words(PHASE_WORDS);

      wait_until_idle();
      apply_settings(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 12'(board.line_no + 1));
      run_words(PHASE_WORDS);

      wait_until_idle();
      if (board.pending_pixels.size() != 0)
         board.flag_failure($sformatf("%0d expected result words never arrived",
                                      board.pending_pixels.size()));
      $display("Covered %0d pixel ticks over %0d line ends and %0d memory writes under %0d settings.",
               board.ticks, board.lines_swept, board.writes, settings_applied);
      $display("Raster interrupts: %0d, with sender gaps, receiver stalls and full rate.",
               board.irqs);
      if (board.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
